@@ rtl/cte_pkg.sv @@
// Package for the circle / triangle-edge contact block.
// Holds the shared sizing constants and the lane control struct.
// No dependencies.
package cte_pkg;

   localparam int CTE_COORD_BITS  = 16;
   localparam int CTE_LANES       = 3;
   localparam int CTE_LANE_STAGES = 6;
   // input stage, lane stages, output register
   localparam int CTE_DEPTH       = CTE_LANE_STAGES + 2;

   typedef struct packed {
      logic [CTE_LANE_STAGES-1:0] load;
   } lane_ctl_type;

endpackage

@@ rtl/cte_if.sv @@
// Request and response channel interfaces for the contact block.
// Depends on cte_pkg for the default coordinate width.
interface cte_req_if import cte_pkg::*; #(
   parameter int COORD_BITS = CTE_COORD_BITS
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic        [COORD_BITS-2:0] radius;
   logic signed [COORD_BITS-1:0] vertex_a_x;
   logic signed [COORD_BITS-1:0] vertex_a_y;
   logic signed [COORD_BITS-1:0] vertex_b_x;
   logic signed [COORD_BITS-1:0] vertex_b_y;
   logic signed [COORD_BITS-1:0] vertex_c_x;
   logic signed [COORD_BITS-1:0] vertex_c_y;

   modport source (
      output valid, center_x, center_y, radius,
             vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, radius,
             vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
      output ready
   );
endinterface

interface cte_rsp_if;
   logic valid;
   logic ready;
   logic touches;

   modport source (output valid, touches, input ready);
   modport sink (input valid, touches, output ready);
endinterface

@@ rtl/circle_triangle_edge_intersect_top.sv @@
// Top level of the circle / triangle-edge contact block.
// Depends on cte_pkg, cte_if, cte_lane and cte_merge.
//
//   channel | direction | handshake    | payload
//   req_if  | in        | valid/ready  | centre, radius, three vertices
//   rsp_if  | out       | valid/ready  | touches
//
// One request per clock while req_if.ready is high; the stages are an input stage that
// shifts the vertices to the centre and squares the radius, six lane stages,
// and the merged response register.
// Synchronous active-high reset empties the pipeline; data registers are not reset.
// A stalled response holds only the stages behind it that are full; empty
// stages keep taking requests, so req_if.ready is high whenever any bubble remains.
module circle_triangle_edge_intersect_top import cte_pkg::*; #(
   parameter int COORD_BITS = CTE_COORD_BITS
) (
   input  logic      clock,
   input  logic      reset,
   cte_req_if.sink   req_if,
   cte_rsp_if.source rsp_if
);

   localparam int REL = COORD_BITS + 1;
   localparam int RRW = 2*COORD_BITS - 2;

   logic [CTE_DEPTH-1:0] adv;
   logic [CTE_DEPTH-1:0] valid_in, valid_ff;

   // a stage moves on when it is empty or the one after it moves
   always_comb begin
      adv[CTE_DEPTH-1] = !valid_ff[CTE_DEPTH-1] || rsp_if.ready;
      for (int i = CTE_DEPTH-2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_if.valid : valid_ff[0];
      for (int i = 1; i < CTE_DEPTH; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready = adv[0];
   assign rsp_if.valid = valid_ff[CTE_DEPTH-1];

   // input stage: vertices relative to the centre, radius squared
   logic signed [COORD_BITS-1:0] vx [CTE_LANES];
   logic signed [COORD_BITS-1:0] vy [CTE_LANES];
   logic signed [REL-1:0]        px_ff [CTE_LANES];
   logic signed [REL-1:0]        py_ff [CTE_LANES];
   logic [RRW-1:0]               rr_ff;

   always_comb begin
      vx[0] = req_if.vertex_a_x;
      vy[0] = req_if.vertex_a_y;
      vx[1] = req_if.vertex_b_x;
      vy[1] = req_if.vertex_b_y;
      vx[2] = req_if.vertex_c_x;
      vy[2] = req_if.vertex_c_y;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int k = 0; k < CTE_LANES; k++) begin
            px_ff[k] <= REL'(vx[k]) - REL'(req_if.center_x);
            py_ff[k] <= REL'(vy[k]) - REL'(req_if.center_y);
         end
         rr_ff <= RRW'(req_if.radius) * RRW'(req_if.radius);
      end
   end

   lane_ctl_type         lane_ctl;
   logic [CTE_LANES-1:0] hit;

   assign lane_ctl.load = adv[CTE_LANE_STAGES:1];

   for (genvar k = 0; k < CTE_LANES; k++) begin : g_lane
      localparam int J = (k == CTE_LANES-1) ? 0 : k + 1;
      cte_lane #(
         .COORD_BITS(COORD_BITS)
      ) u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .x1    (px_ff[k]),
         .y1    (py_ff[k]),
         .x2    (px_ff[J]),
         .y2    (py_ff[J]),
         .rr    (rr_ff),
         .hit   (hit[k])
      );
   end

   cte_merge u_merge (
      .clock   (clock),
      .load    (adv[CTE_DEPTH-1]),
      .hit     (hit),
      .touches (rsp_if.touches)
   );

endmodule

@@ rtl/cte_lane.sv @@
// One edge lane: pipelined exact integer test of one triangle edge against the circle.
// Coordinates arrive relative to the centre. Depends on cte_pkg.
module cte_lane import cte_pkg::*; #(
   parameter int COORD_BITS = CTE_COORD_BITS
) (
   input  logic                         clock,
   input  lane_ctl_type                 ctl,
   input  logic signed [COORD_BITS:0]   x1,
   input  logic signed [COORD_BITS:0]   y1,
   input  logic signed [COORD_BITS:0]   x2,
   input  logic signed [COORD_BITS:0]   y2,
   input  logic [2*COORD_BITS-3:0]      rr,
   output logic                         hit
);

   localparam int REL  = COORD_BITS + 1;
   localparam int DW   = COORD_BITS + 2;
   localparam int RRW  = 2*COORD_BITS - 2;
   localparam int SQW  = 2*REL;
   localparam int LW   = 2*COORD_BITS + 3;
   localparam int XDW  = REL + DW;
   localparam int DOTW = XDW + 1;
   localparam int CRW  = SQW + 1;
   localparam int CM   = SQW;
   localparam int H    = CM / 2;
   localparam int RH   = COORD_BITS - 1;
   localparam int LL   = COORD_BITS + 2;
   localparam int LH   = LW - LL;
   localparam int CW   = 2*CM;

   typedef struct packed {
      logic zero;
      logic far_ok;
      logic near_ok;
      logic foot;
   } edge_flags_type;

   // stage 1: edge vector and all products
   logic signed [DW-1:0]    dx, dy;
   logic signed [2*DW-1:0]  dxdx_ff, dydy_ff;
   logic signed [SQW-1:0]   x1x1_ff, y1y1_ff, x2x2_ff, y2y2_ff, x1y2_ff, x2y1_ff;
   logic signed [XDW-1:0]   x1dx_ff, y1dy_ff, x2dx_ff, y2dy_ff;
   logic                    zero1_ff;
   logic [RRW-1:0]          rr1_ff;

   assign dx = DW'(x2) - DW'(x1);
   assign dy = DW'(y2) - DW'(y1);

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         dxdx_ff  <= dx * dx;
         dydy_ff  <= dy * dy;
         x1x1_ff  <= x1 * x1;
         y1y1_ff  <= y1 * y1;
         x2x2_ff  <= x2 * x2;
         y2y2_ff  <= y2 * y2;
         x1y2_ff  <= x1 * y2;
         x2y1_ff  <= x2 * y1;
         x1dx_ff  <= XDW'(x1) * XDW'(dx);
         y1dy_ff  <= XDW'(y1) * XDW'(dy);
         x2dx_ff  <= XDW'(x2) * XDW'(dx);
         y2dy_ff  <= XDW'(y2) * XDW'(dy);
         zero1_ff <= (dx == '0) && (dy == '0);
         rr1_ff   <= rr;
      end
   end

   // stage 2: sums
   logic [LW-1:0]           len2_ff;
   logic [SQW-1:0]          d1_ff, d2_ff;
   logic signed [DOTW-1:0]  dot1_ff, dot2_ff;
   logic signed [CRW-1:0]   cr_ff;
   logic                    zero2_ff;
   logic [RRW-1:0]          rr2_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         len2_ff  <= LW'(dxdx_ff) + LW'(dydy_ff);
         d1_ff    <= x1x1_ff + y1y1_ff;
         d2_ff    <= x2x2_ff + y2y2_ff;
         dot1_ff  <= DOTW'(x1dx_ff) + DOTW'(y1dy_ff);
         dot2_ff  <= DOTW'(x2dx_ff) + DOTW'(y2dy_ff);
         cr_ff    <= CRW'(x1y2_ff) - CRW'(x2y1_ff);
         zero2_ff <= zero1_ff;
         rr2_ff   <= rr1_ff;
      end
   end

   // stage 3: cross magnitude and endpoint decisions
   logic [CRW-1:0]          cr_abs;
   logic [SQW-1:0]          rr_wide;
   edge_flags_type          flags3_in, flags3_ff;
   logic [CM-1:0]           cmag3_ff;
   logic [LW-1:0]           len3_ff;
   logic [RRW-1:0]          rr3_ff;

   assign cr_abs  = cr_ff[CRW-1] ? CRW'(-cr_ff) : CRW'(cr_ff);
   assign rr_wide = SQW'(rr2_ff);

   always_comb begin
      flags3_in.zero    = zero2_ff;
      flags3_in.far_ok  = (d1_ff >= rr_wide) || (d2_ff >= rr_wide);
      flags3_in.near_ok = (d1_ff <= rr_wide) || (d2_ff <= rr_wide);
      // foot of the perpendicular lies within the edge
      flags3_in.foot    = (dot1_ff <= 0) && (dot2_ff >= 0);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         cmag3_ff  <= cr_abs[CM-1:0];
         len3_ff   <= len2_ff;
         rr3_ff    <= rr2_ff;
         flags3_ff <= flags3_in;
      end
   end

   // stage 4: partial products of cross^2 and rr * len2
   logic [H-1:0]            cm_lo, cm_hi;
   logic [RH-1:0]           rr_lo;
   logic [RRW-RH-1:0]       rr_hi;
   logic [LL-1:0]           len_lo;
   logic [LH-1:0]           len_hi;
   logic [2*H-1:0]          p_ll_ff, p_lh_ff, p_hh_ff;
   logic [RH+LL-1:0]        q_ll_ff;
   logic [RH+LH-1:0]        q_lh_ff;
   logic [RRW-RH+LL-1:0]    q_hl_ff;
   logic [RRW-RH+LH-1:0]    q_hh_ff;
   edge_flags_type          flags4_ff;

   assign cm_lo  = cmag3_ff[H-1:0];
   assign cm_hi  = cmag3_ff[CM-1:H];
   assign rr_lo  = rr3_ff[RH-1:0];
   assign rr_hi  = rr3_ff[RRW-1:RH];
   assign len_lo = len3_ff[LL-1:0];
   assign len_hi = len3_ff[LW-1:LL];

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         p_ll_ff   <= (2*H)'(cm_lo) * (2*H)'(cm_lo);
         p_lh_ff   <= (2*H)'(cm_lo) * (2*H)'(cm_hi);
         p_hh_ff   <= (2*H)'(cm_hi) * (2*H)'(cm_hi);
         q_ll_ff   <= (RH+LL)'(rr_lo) * (RH+LL)'(len_lo);
         q_lh_ff   <= (RH+LH)'(rr_lo) * (RH+LH)'(len_hi);
         q_hl_ff   <= (RRW-RH+LL)'(rr_hi) * (RRW-RH+LL)'(len_lo);
         q_hh_ff   <= (RRW-RH+LH)'(rr_hi) * (RRW-RH+LH)'(len_hi);
         flags4_ff <= flags3_ff;
      end
   end

   // stage 5: recombine the partial products
   logic [CW-1:0]           cm2_ff, rl_ff;
   edge_flags_type          flags5_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         cm2_ff    <= (CW'(p_hh_ff) << (2*H)) + (CW'(p_lh_ff) << (H+1)) + CW'(p_ll_ff);
         rl_ff     <= (CW'(q_hh_ff) << (RH+LL)) + (CW'(q_hl_ff) << RH)
                      + (CW'(q_lh_ff) << LL) + CW'(q_ll_ff);
         flags5_ff <= flags4_ff;
      end
   end

   // stage 6: final decision
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         hit_ff <= !flags5_ff.zero && flags5_ff.far_ok &&
                   (flags5_ff.foot ? (cm2_ff <= rl_ff) : flags5_ff.near_ok);
      end
   end

   assign hit = hit_ff;

endmodule

@@ rtl/cte_merge.sv @@
// Merge stage: combines the edge lanes' hits into the response register.
// Depends on cte_pkg for the lane count.
module cte_merge import cte_pkg::*; (
   input  logic                 clock,
   input  logic                 load,
   input  logic [CTE_LANES-1:0] hit,
   output logic                 touches
);

   logic touches_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         touches_ff <= |hit;
      end
   end

   assign touches = touches_ff;

endmodule

@@ rtl/cte_checker.sv @@
// Port-level checker for the contact block, attached to the top level by bind.
// Depends on cte_pkg for the pipeline depth.
module cte_checker import cte_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_touches
);

   localparam int CNTW = $clog2(CTE_DEPTH + 2);

   logic [CNTW-1:0] count_in, count_ff;

   // requests in flight: accepted but not yet delivered
   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready) begin
         count_in = count_in + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CTE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !rsp_valid)
      else $error("response shown with no request in flight");

   a_ready_when_draining: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused while the output can move");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_touches)))
      else $error("stalled response dropped or changed");

endmodule

bind circle_triangle_edge_intersect_top cte_checker u_cte_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_touches (rsp_if.touches)
);

@@ tb/tb_top.sv @@
// Self-checking bench for circle_triangle_edge_intersect_top.
// Drives contact queries through cte_req_if and checks every touches response
// against a known answer or an in-bench integer model. Depends on cte_pkg and cte_if.
`timescale 1ns / 1ps

module tb_top;
   import cte_pkg::*;

   typedef struct {
      logic signed [CTE_COORD_BITS-1:0] center_x;
      logic signed [CTE_COORD_BITS-1:0] center_y;
      logic        [CTE_COORD_BITS-2:0] radius;
      logic signed [CTE_COORD_BITS-1:0] vertex_a_x;
      logic signed [CTE_COORD_BITS-1:0] vertex_a_y;
      logic signed [CTE_COORD_BITS-1:0] vertex_b_x;
      logic signed [CTE_COORD_BITS-1:0] vertex_b_y;
      logic signed [CTE_COORD_BITS-1:0] vertex_c_x;
      logic signed [CTE_COORD_BITS-1:0] vertex_c_y;
   } contact_query_type;

   // known_touch < 0: take the answer from the contact model
   typedef struct {
      int cx, cy, r, ax, ay, bx, by, qx, qy, known_touch;
   } directed_row_type;

   localparam int NUM_DIRECTED = 20;
   localparam int COORD_MAX    = 32767;
   localparam int COORD_MIN    = -32768;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},                  // every edge zero length
      '{0, 0, 0, -5, 0, 5, 0, 0, 7, 1},                 // point circle on an edge
      '{0, 0, 0, 1, 1, 5, 1, 3, 7, 0},                  // point circle off the edges
      '{0, 0, 10, -20, 0, 20, 0, 0, 20, 1},             // edge crosses the circle
      '{0, 0, 100, -10, -10, 10, -10, 0, 10, 0},        // triangle wholly inside
      '{0, 0, 10, 1000, 1000, 1100, 1000, 1000, 1100, 0},
      '{0, 0, 10, -20, 10, 20, 10, 0, 30, 1},           // tangent edge
      '{0, 0, 10, -20, 11, 20, 11, 0, 30, 0},           // just clear of tangent
      '{0, 0, 10, 10, 0, 0, 0, 0, 1, 1},                // vertex on circumference
      '{0, 0, 5, -10, 0, 0, 0, 10, 0, 1},               // collinear vertices
      '{0, 0, 5, 10, 10, 20, 20, 30, 30, 0},            // collinear, misses
      '{0, 0, 10, 5, 0, 5, 0, 20, 0, 1},                // two vertices coincide
      '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
        COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, -1},
      '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
        COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, -1},
      '{COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 1},
      '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
        COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 0},
      '{0, 0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, -1},
      '{0, 0, 1, 1, -1, 1, 1, -5, 0, 1},                // tangent at unit radius
      '{0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32000, 32000, COORD_MAX, -1},
      '{21845, -21846, 21845, -21846, 21845, 21845, -21846, -1, -1, -1}
   };

   logic clock = 1'b0;
   logic reset;

   cte_req_if req_if ();
   cte_rsp_if rsp_if ();

   circle_triangle_edge_intersect_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   bit touches_due [$];
   int mismatches        = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- contact model

   function automatic bit edge_contact(longint x1, longint y1, longint x2, longint y2,
                                       longint rr);
      longint dx, dy, len2, d1, d2, dmax, dmin, dot1, dot2, cr, cmag;
      logic [127:0] cross_sq, bound;
      dx = x2 - x1;
      dy = y2 - y1;
      if (dx == 0 && dy == 0)
         return 1'b0;
      len2 = dx * dx + dy * dy;
      d1   = x1 * x1 + y1 * y1;
      d2   = x2 * x2 + y2 * y2;
      dmax = (d1 > d2) ? d1 : d2;
      dmin = (d1 < d2) ? d1 : d2;
      if (dmax < rr)
         return 1'b0;
      dot1 = x1 * dx + y1 * dy;
      dot2 = x2 * dx + y2 * dy;
      // foot of the perpendicular lies on the edge
      if (dot1 <= 0 && dot2 >= 0) begin
         cr       = x1 * y2 - x2 * y1;
         cmag     = (cr < 0) ? -cr : cr;
         cross_sq = cmag;
         cross_sq = cross_sq * cross_sq;
         bound    = rr;
         bound    = bound * len2;
         return cross_sq <= bound;
      end
      return dmin <= rr;
   endfunction

   function automatic bit circle_meets_triangle(contact_query_type q);
      longint rr;
      longint px [3];
      longint py [3];
      bit     hit;
      rr    = longint'(q.radius) * longint'(q.radius);
      px[0] = longint'(q.vertex_a_x) - longint'(q.center_x);
      py[0] = longint'(q.vertex_a_y) - longint'(q.center_y);
      px[1] = longint'(q.vertex_b_x) - longint'(q.center_x);
      py[1] = longint'(q.vertex_b_y) - longint'(q.center_y);
      px[2] = longint'(q.vertex_c_x) - longint'(q.center_x);
      py[2] = longint'(q.vertex_c_y) - longint'(q.center_y);
      hit   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (edge_contact(px[i], py[i], px[(i + 1) % 3], py[(i + 1) % 3], rr))
            hit = 1'b1;
      end
      return hit;
   endfunction

   // ---------------------------------------------------------------- query shapes

   function automatic logic signed [CTE_COORD_BITS-1:0] clamp_coord(int v);
      if (v > COORD_MAX)
         return CTE_COORD_BITS'(COORD_MAX);
      if (v < COORD_MIN)
         return CTE_COORD_BITS'(COORD_MIN);
      return CTE_COORD_BITS'(v);
   endfunction

   function automatic int near_offset(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [CTE_COORD_BITS-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0:       return CTE_COORD_BITS'(COORD_MIN);
         1:       return CTE_COORD_BITS'(COORD_MAX);
         2:       return CTE_COORD_BITS'(0);
         3:       return CTE_COORD_BITS'(-1);
         default: return CTE_COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic contact_query_type random_query();
      contact_query_type q;
      int ox, oy, span, dx, dy, k1, k2;
      q    = '{default: '0};
      ox   = int'($urandom_range(0, 60000)) - 30000;
      oy   = int'($urandom_range(0, 60000)) - 30000;
      span = 1 << $urandom_range(1, 11);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            q.center_x   = CTE_COORD_BITS'($urandom);
            q.center_y   = CTE_COORD_BITS'($urandom);
            q.radius     = (CTE_COORD_BITS - 1)'($urandom);
            q.vertex_a_x = CTE_COORD_BITS'($urandom);
            q.vertex_a_y = CTE_COORD_BITS'($urandom);
            q.vertex_b_x = CTE_COORD_BITS'($urandom);
            q.vertex_b_y = CTE_COORD_BITS'($urandom);
            q.vertex_c_x = CTE_COORD_BITS'($urandom);
            q.vertex_c_y = CTE_COORD_BITS'($urandom);
         end
         6: begin
            // point or unit-radius circle at the middle of edge A-B, or just beside it
            dx           = near_offset(span);
            dy           = near_offset(span);
            q.radius     = (CTE_COORD_BITS - 1)'(($urandom_range(0, 3) == 0) ? 1 : 0);
            q.vertex_a_x = clamp_coord(ox);
            q.vertex_a_y = clamp_coord(oy);
            q.vertex_b_x = clamp_coord(ox + 2 * dx);
            q.vertex_b_y = clamp_coord(oy + 2 * dy);
            q.center_x   = clamp_coord(ox + dx + near_offset(1));
            q.center_y   = clamp_coord(oy + dy + near_offset(1));
            q.vertex_c_x = clamp_coord(ox + near_offset(span));
            q.vertex_c_y = clamp_coord(oy + near_offset(span));
         end
         7: begin
            // repeated vertices
            q.center_x   = clamp_coord(ox + near_offset(span));
            q.center_y   = clamp_coord(oy + near_offset(span));
            q.radius     = (CTE_COORD_BITS - 1)'($urandom_range(0, 2 * span));
            q.vertex_a_x = clamp_coord(ox);
            q.vertex_a_y = clamp_coord(oy);
            q.vertex_b_x = q.vertex_a_x;
            q.vertex_b_y = q.vertex_a_y;
            if ($urandom_range(0, 1)) begin
               q.vertex_c_x = q.vertex_a_x;
               q.vertex_c_y = q.vertex_a_y;
            end else begin
               q.vertex_c_x = clamp_coord(ox + near_offset(span));
               q.vertex_c_y = clamp_coord(oy + near_offset(span));
            end
         end
         8: begin
            q.center_x   = extreme_coord();
            q.center_y   = extreme_coord();
            case ($urandom_range(0, 2))
               0:       q.radius = '0;
               1:       q.radius = (CTE_COORD_BITS - 1)'(COORD_MAX);
               default: q.radius = (CTE_COORD_BITS - 1)'($urandom);
            endcase
            q.vertex_a_x = extreme_coord();
            q.vertex_a_y = extreme_coord();
            q.vertex_b_x = extreme_coord();
            q.vertex_b_y = extreme_coord();
            q.vertex_c_x = extreme_coord();
            q.vertex_c_y = extreme_coord();
         end
         9: begin
            // collinear vertices
            dx           = near_offset(span / 2 + 1);
            dy           = near_offset(span / 2 + 1);
            k1           = int'($urandom_range(0, 8)) - 4;
            k2           = int'($urandom_range(0, 8)) - 4;
            q.center_x   = clamp_coord(ox + near_offset(span));
            q.center_y   = clamp_coord(oy + near_offset(span));
            q.radius     = (CTE_COORD_BITS - 1)'($urandom_range(0, 2 * span));
            q.vertex_a_x = clamp_coord(ox);
            q.vertex_a_y = clamp_coord(oy);
            q.vertex_b_x = clamp_coord(ox + k1 * dx);
            q.vertex_b_y = clamp_coord(oy + k1 * dy);
            q.vertex_c_x = clamp_coord(ox + k2 * dx);
            q.vertex_c_y = clamp_coord(oy + k2 * dy);
         end
         default: begin
            // small triangle near the centre, radius of the same order
            q.center_x   = clamp_coord(ox);
            q.center_y   = clamp_coord(oy);
            q.radius     = (CTE_COORD_BITS - 1)'($urandom_range(0, 2 * span));
            q.vertex_a_x = clamp_coord(ox + near_offset(span));
            q.vertex_a_y = clamp_coord(oy + near_offset(span));
            q.vertex_b_x = clamp_coord(ox + near_offset(span));
            q.vertex_b_y = clamp_coord(oy + near_offset(span));
            q.vertex_c_x = clamp_coord(ox + near_offset(span));
            q.vertex_c_y = clamp_coord(oy + near_offset(span));
         end
      endcase
      return q;
   endfunction

   // ---------------------------------------------------------------- request driver

   // entered and left at a falling edge
   task automatic send_query(input contact_query_type q, input bit want_touch);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.center_x   <= q.center_x;
      req_if.center_y   <= q.center_y;
      req_if.radius     <= q.radius;
      req_if.vertex_a_x <= q.vertex_a_x;
      req_if.vertex_a_y <= q.vertex_a_y;
      req_if.vertex_b_x <= q.vertex_b_x;
      req_if.vertex_b_y <= q.vertex_b_y;
      req_if.vertex_c_x <= q.vertex_c_x;
      req_if.vertex_c_y <= q.vertex_c_y;
      do
         @(posedge clock);
      while (!req_if.ready);
      touches_due = {touches_due, want_touch};
      @(negedge clock);
   endtask

   // hold ready low through reset
   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // ---------------------------------------------------------------- response check

   always @(posedge clock) begin
      bit want_touch;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (touches_due.size() == 0) begin
            $error("touches: expected none, actual %0d", rsp_if.touches);
            mismatches++;
         end else begin
            want_touch = touches_due.pop_front();
            if (rsp_if.touches !== want_touch) begin
               $error("touches: expected %0d, actual %0d", want_touch, rsp_if.touches);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      contact_query_type q;
      bit want_touch;
      int phase_items [3] = '{700, 700, 600};
      int sender_pcts [3] = '{28, 72, 0};
      int receiver_pcts [3] = '{72, 28, 0};

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.center_x   = '0;
      req_if.center_y   = '0;
      req_if.radius     = '0;
      req_if.vertex_a_x = '0;
      req_if.vertex_a_y = '0;
      req_if.vertex_b_x = '0;
      req_if.vertex_b_y = '0;
      req_if.vertex_c_x = '0;
      req_if.vertex_c_y = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = sender_pcts[phase];
         receiver_idle_pct = receiver_pcts[phase];
         if (phase == 0) begin
            foreach (directed_rows[i]) begin
               q.center_x   = CTE_COORD_BITS'(directed_rows[i].cx);
               q.center_y   = CTE_COORD_BITS'(directed_rows[i].cy);
               q.radius     = (CTE_COORD_BITS - 1)'(directed_rows[i].r);
               q.vertex_a_x = CTE_COORD_BITS'(directed_rows[i].ax);
               q.vertex_a_y = CTE_COORD_BITS'(directed_rows[i].ay);
               q.vertex_b_x = CTE_COORD_BITS'(directed_rows[i].bx);
               q.vertex_b_y = CTE_COORD_BITS'(directed_rows[i].by);
               q.vertex_c_x = CTE_COORD_BITS'(directed_rows[i].qx);
               q.vertex_c_y = CTE_COORD_BITS'(directed_rows[i].qy);
               if (directed_rows[i].known_touch < 0)
                  want_touch = circle_meets_triangle(q);
               else
                  want_touch = directed_rows[i].known_touch[0];
               send_query(q, want_touch);
            end
         end
         for (int n = 0; n < phase_items[phase]; n++) begin
            q = random_query();
            send_query(q, circle_meets_triangle(q));
         end
      end
      req_if.valid <= 1'b0;

      wait (touches_due.size() == 0);
      repeat (4 * CTE_DEPTH) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
